FILE: sv/cwb_pkg.sv
// cwb_pkg: request, result and buffer entry types, state and status codes
// for the coalescing write buffer. No dependencies.
package cwb_pkg;

  localparam int ENT_W   = 6;
  localparam int CNT_W   = 5;
  localparam int KEY_W   = 32;

  localparam logic [ENT_W-1:0] SLOT_EMPTY = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STAT_MERGED   = 2'd0;
  localparam logic [1:0] STAT_APPENDED = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;
  localparam logic [1:0] STAT_FLUSHED  = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [63:0] set_handle;
    logic [15:0] binding;
    logic [15:0] arr_elem;
    logic [63:0] payload;
    logic [15:0] descriptor_count;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [63:0]      out_set_handle;
    logic [15:0]      out_binding;
    logic [15:0]      out_arr_elem;
    logic [63:0]      out_payload;
    logic [CNT_W-1:0] out_count;
    logic [5:0]       pending_count;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [63:0]      set_handle;
    logic [15:0]      binding;
    logic [15:0]      element;
    logic [63:0]      payload;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_SLOT,
    S_ENTRY,
    S_FL_RD,
    S_FL_EMIT,
    S_APPEND,
    S_STATUS
  } state_t;

endpackage

FILE: sv/cwb_ifs.sv
// Channel interfaces: request, result and configuration write.
// Depends on cwb_pkg.
interface cwb_req_if;
  logic          valid;
  logic          ready;
  cwb_pkg::req_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface cwb_rsp_if;
  logic          valid;
  logic          ready;
  cwb_pkg::rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

interface cwb_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/cwb_hash.sv
// cwb_hash: home slot of a 32-bit key modulo HASH_SLOTS by reciprocal multiply,
// one registered product then one correction step. Depends on cwb_pkg.
module cwb_hash #(
  parameter int HASH_SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cwb_pkg::KEY_W-1:0]     key,
  output logic                          done,
  output logic [$clog2(HASH_SLOTS)-1:0] slot
);
  import cwb_pkg::*;

  localparam int SW = $clog2(HASH_SLOTS);
  localparam int RECIP_SH = 37;
  localparam logic [63:0] RECIP_W = (64'd1 << RECIP_SH) / 64'(HASH_SLOTS);
  localparam logic [KEY_W-1:0] RECIP = RECIP_W[KEY_W-1:0];
  localparam logic [KEY_W-1:0] MOD = KEY_W'(HASH_SLOTS);

  logic [KEY_W-1:0]   key_r;
  logic [2*KEY_W-1:0] prod_r;
  logic               step_r;
  logic               busy_r;
  logic [KEY_W-1:0]   quo;
  logic [KEY_W-1:0]   diff;
  logic [KEY_W-1:0]   rem;

  // quotient estimate is exact or one low
  assign quo  = KEY_W'(prod_r >> RECIP_SH);
  assign diff = key_r - quo * MOD;
  assign rem  = (diff >= MOD) ? diff - MOD : diff;

  assign done = busy_r && step_r;
  assign slot = rem[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 1'b0;
    end else if (busy_r) begin
      step_r <= 1'b1;
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    if (busy_r && !step_r) begin
      prod_r <= 64'(key_r) * 64'(RECIP);
    end
  end

endmodule

FILE: sv/coalescing_write_buffer_core.sv
// Coalescing write buffer: append buffer in an entry RAM, linear-probe slot RAM index.
// Status follows the probe walk for a write and the entry walk for a flush; a full-buffer
// write adds the flush walk. Hash: reciprocal multiply.
// One request at a time; the next is taken once the status result is registered.
// Reset empties the buffer and index at once (slot valid flops) and clears the lost flag.
// Depends on cwb_pkg, cwb_ifs, cwb_hash.
module coalescing_write_buffer_core #(
  parameter int BUFFER_ENTRIES = 32,
  parameter int HASH_SLOTS     = 256,
  parameter int COUNT_LIMIT    = 16
) (
  input logic       clk,
  input logic       rst_n,
  cwb_req_if.sink   in_ch,
  cwb_rsp_if.source out_ch,
  cwb_cfg_if.sink   cfg_ch
);
  import cwb_pkg::*;

  localparam int SW = $clog2(HASH_SLOTS);
  localparam int AW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [SW-1:0]    home_r, home_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    ent_r, ent_nxt;
  logic [ENT_W-1:0] idx_r, idx_nxt;
  logic [ENT_W-1:0] fill_r, fill_nxt;
  logic [5:0]       pend_r, pend_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [HASH_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic             lost_r;
  logic             out_v_r;
  rsp_t             out_rsp_r;

  entry_t           ent_mem [BUFFER_ENTRIES];
  entry_t           ent_rd_r;
  logic [ENT_W-1:0] slot_mem [HASH_SLOTS];
  logic [ENT_W-1:0] slot_rd_r;

  logic             out_free;
  logic             out_load;
  rsp_t             out_data;
  logic             ent_we;
  logic [AW-1:0]    ent_waddr;
  entry_t           ent_wdata;
  logic [AW-1:0]    ent_raddr;
  logic             slot_we;
  logic             hash_start;
  logic             hash_done;
  logic [SW-1:0]    hash_slot;
  logic             hit;
  logic [CNT_W-1:0] cnt_sat;
  logic [KEY_W-1:0] key;

  assign key = {req_nxt.set_handle[15:0], 16'h0}
             | {8'h0, req_nxt.binding, 8'h0}
             | {24'h0, req_nxt.arr_elem[7:0]};

  cwb_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  assign out_free = !out_v_r || out_ch.ready;
  assign hit = (ent_rd_r.set_handle == req_r.set_handle)
            && (ent_rd_r.binding == req_r.binding)
            && (ent_rd_r.element == req_r.arr_elem);
  assign cnt_sat = (req_r.descriptor_count > 16'(COUNT_LIMIT))
                 ? CNT_W'(COUNT_LIMIT) : req_r.descriptor_count[CNT_W-1:0];

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.rsp   = out_rsp_r;

  // next state
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    home_nxt     = home_r;
    slot_nxt     = slot_r;
    ent_nxt      = ent_r;
    idx_nxt      = idx_r;
    fill_nxt     = fill_r;
    pend_nxt     = pend_r;
    stat_nxt     = stat_r;
    slot_vld_nxt = slot_vld_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.req;
          if (lost_r) begin
            stat_nxt  = STAT_REJECTED;
            state_nxt = S_STATUS;
          end else if (in_ch.req.operation == OP_FLUSH) begin
            stat_nxt = STAT_FLUSHED;
            idx_nxt  = '0;
            pend_nxt = '0;
            state_nxt = (fill_r == '0) ? S_STATUS : S_FL_RD;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          home_nxt  = hash_slot;
          slot_nxt  = hash_slot;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!slot_vld_r[slot_r]) begin
          if (fill_r == ENT_W'(BUFFER_ENTRIES)) begin
            idx_nxt   = '0;
            pend_nxt  = 6'd1;
            state_nxt = S_FL_RD;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        ent_nxt   = slot_rd_r[AW-1:0];
        state_nxt = S_ENTRY;
      end
      S_ENTRY: begin
        if (hit) begin
          stat_nxt  = STAT_MERGED;
          state_nxt = S_STATUS;
        end else begin
          slot_nxt  = (slot_r == SW'(HASH_SLOTS - 1)) ? '0 : slot_r + 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_FL_RD: begin
        state_nxt = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (out_free) begin
          if (idx_r + 1'b1 == fill_r) begin
            fill_nxt     = '0;
            slot_vld_nxt = '0;
            if (req_r.operation == OP_FLUSH) begin
              state_nxt = S_STATUS;
            end else begin
              slot_nxt  = home_r;
              state_nxt = S_APPEND;
            end
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_FL_RD;
          end
        end
      end
      S_APPEND: begin
        slot_vld_nxt[slot_r] = 1'b1;
        fill_nxt  = fill_r + 1'b1;
        stat_nxt  = STAT_APPENDED;
        state_nxt = S_STATUS;
      end
      S_STATUS: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ch.ready = 1'b0;
    hash_start  = 1'b0;
    out_load    = 1'b0;
    out_data    = '0;
    ent_we      = 1'b0;
    ent_waddr   = fill_r[AW-1:0];
    ent_wdata   = '{set_handle: req_r.set_handle, binding: req_r.binding,
                    element: req_r.arr_elem, payload: req_r.payload,
                    count: cnt_sat};
    ent_raddr   = idx_r[AW-1:0];
    slot_we     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        hash_start  = in_ch.valid && !lost_r && (in_ch.req.operation == OP_WRITE);
      end
      S_SLOT: begin
        ent_raddr = slot_rd_r[AW-1:0];
      end
      S_ENTRY: begin
        ent_waddr = ent_r;
        ent_we    = hit;
      end
      S_FL_EMIT: begin
        out_load = out_free;
        out_data = '{kind: KIND_ENTRY, status: STAT_FLUSHED,
                     out_set_handle: ent_rd_r.set_handle,
                     out_binding: ent_rd_r.binding,
                     out_arr_elem: ent_rd_r.element,
                     out_payload: ent_rd_r.payload, out_count: ent_rd_r.count,
                     pending_count: pend_r, last: 1'b0};
      end
      S_APPEND: begin
        ent_we  = 1'b1;
        slot_we = 1'b1;
      end
      S_STATUS: begin
        out_load = out_free;
        out_data = '{kind: KIND_STATUS, status: stat_r, out_set_handle: '0,
                     out_binding: '0, out_arr_elem: '0, out_payload: '0,
                     out_count: '0, pending_count: 6'(fill_r), last: 1'b1};
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      slot_vld_r <= '0;
      lost_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      slot_vld_r <= slot_vld_nxt;
      if (cfg_ch.valid) begin
        lost_r <= cfg_ch.data;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    home_r <= home_nxt;
    slot_r <= slot_nxt;
    ent_r  <= ent_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_rsp_r <= out_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_r] <= fill_r & SLOT_EMPTY;
    end
    slot_rd_r <= slot_mem[slot_r];
  end

endmodule
